// ----- hdl/ole_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ole_pkg;
    localparam int CAPACITY_DEF = 16;
    localparam int ACTION_W = 3;
    localparam int POS_W = 8;
    localparam int VALUE_W = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INS_HEAD = 3'd0,
        ACT_INS_END  = 3'd1,
        ACT_INS_MID  = 3'd2,
        ACT_INS_POS  = 3'd3,
        ACT_DEL_HEAD = 3'd4,
        ACT_DEL_VAL  = 3'd5,
        ACT_DEL_POS  = 3'd6,
        ACT_DUMP     = 3'd7
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;
endpackage
`default_nettype wire

// ----- hdl/ordered_list_engine_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Beat contents
// s_axis    in         tdata: action, position, item_value
// m_axis    out        tdata: status, out_value, entry_count; tlast: last
// Entries live in a one-port-read, one-port-write RAM with a registered read port.
// Inserts and deletes move one entry at a time, in a read step and then a write-back
// step. Delete by value scans the entries, a read and then a compare for each, and
// then shifts. Dump reads each entry in turn and then gives it as one beat.
// Reset clears the count and the control and output registers; the RAM needs no clearing.
// A result waits in the output register while tready is low; the walk stalls with it.
module ordered_list_engine_unit #(
    parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // action[2:0], position[10:3], item_value[42:11]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // status[1:0], out_value[33:2], entry_count[38:34]
    output logic             m_axis_tlast
);
    import ole_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SHUP, S_SHDN, S_DUMP, S_OUT} state_t;

    logic [VALUE_W-1:0] mem [CAPACITY];
    logic [VALUE_W-1:0] rdata_reg;
    logic [AW-1:0]      raddr;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [VALUE_W-1:0] wdata;

    state_t             state_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      idx_reg;
    logic [CW-1:0]      tgt_reg;
    logic               rd_pend_reg;
    action_t            act_reg;
    logic [VALUE_W-1:0] val_reg;
    logic               ovalid_reg;
    logic [STATUS_W-1:0] ost_reg;
    logic [VALUE_W-1:0] oval_reg;
    logic [CW-1:0]      ocnt_reg;
    logic               olast_reg;

    action_t            in_act;
    logic [PW-1:0]      in_pos;
    logic [PW-1:0]      cnt_w;
    logic               out_free;

    assign in_act = action_t'(s_axis_tdata[2:0]);
    assign in_pos = (s_axis_tdata[10:3] == '0) ? PW'(2) : PW'(s_axis_tdata[10:3]);
    assign cnt_w = PW'(count_reg);
    assign out_free = !ovalid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tlast = olast_reg;
    assign m_axis_tdata = {1'b0, 5'(ocnt_reg), oval_reg, ost_reg};

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        raddr = idx_reg[AW-1:0];
        we = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = val_reg;
        case (state_reg)
            S_SHUP:
            begin
                // Moving entries up: read idx-1, write it to idx.
                raddr = AW'(idx_reg - 1'b1);
                if (rd_pend_reg)
                begin
                    we = 1'b1;
                    wdata = rdata_reg;
                end
                else if (idx_reg == tgt_reg)
                begin
                    we = 1'b1;
                end
            end
            S_SHDN:
            begin
                // Moving entries down: read idx+1, write it to idx.
                raddr = AW'(idx_reg + 1'b1);
                if (rd_pend_reg)
                begin
                    we = 1'b1;
                    wdata = rdata_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ovalid_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            idx_reg <= '0;
            tgt_reg <= '0;
            act_reg <= ACT_INS_HEAD;
            val_reg <= '0;
            ost_reg <= '0;
            oval_reg <= '0;
            ocnt_reg <= '0;
            olast_reg <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && m_axis_tready)
            begin
                ovalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        act_reg <= in_act;
                        val_reg <= s_axis_tdata[42:11];
                        rd_pend_reg <= 1'b0;
                        ost_reg <= ST_OK;
                        oval_reg <= '0;
                        ocnt_reg <= count_reg;
                        olast_reg <= 1'b1;
                        state_reg <= S_OUT;
                        case (in_act)
                            ACT_INS_HEAD, ACT_INS_END, ACT_INS_MID, ACT_INS_POS:
                            begin
                                idx_reg <= count_reg;
                                state_reg <= S_SHUP;
                                if (count_reg >= CW'(CAPACITY))
                                begin
                                    ost_reg <= ST_FULL;
                                    state_reg <= S_OUT;
                                end
                                else if (in_act == ACT_INS_HEAD)
                                begin
                                    tgt_reg <= '0;
                                end
                                else if (in_act == ACT_INS_END)
                                begin
                                    tgt_reg <= count_reg;
                                end
                                else if (in_act == ACT_INS_MID)
                                begin
                                    tgt_reg <= count_reg >> 1;
                                end
                                else if (in_pos - 1'b1 <= cnt_w)
                                begin
                                    tgt_reg <= CW'(in_pos - 1'b1);
                                end
                                else
                                begin
                                    ost_reg <= ST_NOT_FOUND;
                                    state_reg <= S_OUT;
                                end
                            end
                            ACT_DUMP:
                            begin
                                idx_reg <= '0;
                                if (count_reg == '0)
                                begin
                                    ost_reg <= ST_EMPTY;
                                end
                                else
                                begin
                                    state_reg <= S_DUMP;
                                end
                            end
                            default:
                            begin
                                if (count_reg == '0)
                                begin
                                    ost_reg <= ST_EMPTY;
                                end
                                else if (in_act == ACT_DEL_HEAD)
                                begin
                                    idx_reg <= '0;
                                    state_reg <= S_SCAN;
                                end
                                else if (in_act == ACT_DEL_VAL)
                                begin
                                    idx_reg <= '0;
                                    state_reg <= S_SCAN;
                                end
                                else if (in_pos <= cnt_w)
                                begin
                                    idx_reg <= CW'(in_pos - 1'b1);
                                    state_reg <= S_SCAN;
                                end
                                else
                                begin
                                    ost_reg <= ST_NOT_FOUND;
                                end
                            end
                        endcase
                    end
                end
                S_SHUP:
                begin
                    rd_pend_reg <= 1'b0;
                    if (rd_pend_reg)
                    begin
                        idx_reg <= idx_reg - 1'b1;
                    end
                    else if (idx_reg == tgt_reg)
                    begin
                        count_reg <= count_reg + 1'b1;
                        ocnt_reg <= count_reg + 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b1;
                    end
                end
                S_SCAN:
                begin
                    // Read idx, compare on the next cycle.
                    if (!rd_pend_reg)
                    begin
                        rd_pend_reg <= 1'b1;
                    end
                    else if (act_reg != ACT_DEL_VAL || rdata_reg == val_reg)
                    begin
                        rd_pend_reg <= 1'b0;
                        oval_reg <= rdata_reg;
                        count_reg <= count_reg - 1'b1;
                        ocnt_reg <= count_reg - 1'b1;
                        state_reg <= S_SHDN;
                    end
                    else if (idx_reg + 1'b1 >= count_reg)
                    begin
                        rd_pend_reg <= 1'b0;
                        ost_reg <= ST_NOT_FOUND;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b0;
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_SHDN:
                begin
                    // count_reg is already reduced: shift while idx < count.
                    rd_pend_reg <= 1'b0;
                    if (rd_pend_reg)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else if (idx_reg >= count_reg)
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        rd_pend_reg <= 1'b1;
                    end
                end
                S_DUMP:
                begin
                    if (!rd_pend_reg)
                    begin
                        rd_pend_reg <= 1'b1;
                    end
                    else if (out_free)
                    begin
                        rd_pend_reg <= 1'b0;
                        ovalid_reg <= 1'b1;
                        ost_reg <= ST_OK;
                        oval_reg <= rdata_reg;
                        ocnt_reg <= count_reg;
                        olast_reg <= (idx_reg + 1'b1 == count_reg);
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg + 1'b1 == count_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        ovalid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !s_axis_tready)
        else $error("input accepted while busy");
    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && !m_axis_tready |=> ovalid_reg && $stable(oval_reg))
        else $error("pending result lost");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DUMP |=> $stable(count_reg))
        else $error("count changed during dump");
endmodule
`default_nettype wire

// ----- tb/ordered_list_engine_unit_tb.sv -----
`timescale 1ns / 1ps
module ordered_list_engine_unit_tb;
    import ole_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
        logic [4:0]  count;
        logic        last;
    } list_result_t;

    typedef struct {
        action_t     act;
        logic [7:0]  pos;
        logic [31:0] val;
        bit          typed;
        logic [1:0]  st;
        logic [4:0]  cnt;
    } list_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    logic [31:0] shadow_list [CAP];
    int unsigned shadow_count;
    list_result_t pending_results [$];
    int errors = 0;
    int unsigned cycle_count = 0;
    bit sending_done = 0;
    bit hold_off = 0;
    list_row_t rows [$];

    ordered_list_engine_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic list_result_t make_result(logic [1:0] st, logic [31:0] v, bit lst);
        list_result_t r;
        r.status = st;
        r.value = v;
        r.count = shadow_count[4:0];
        r.last = lst;
        return r;
    endfunction

    task automatic shadow_insert(int unsigned idx, logic [31:0] v);
        for (int unsigned i = shadow_count; i > idx; i--)
            shadow_list[i] = shadow_list[i-1];
        shadow_list[idx] = v;
        shadow_count++;
    endtask

    task automatic shadow_remove(int unsigned idx, output logic [31:0] v);
        v = shadow_list[idx];
        for (int unsigned i = idx; i + 1 < shadow_count; i++)
            shadow_list[i] = shadow_list[i+1];
        shadow_count--;
    endtask

    task automatic predict_list_op(action_t act, logic [7:0] pos_in, logic [31:0] v);
        int unsigned pos;
        logic [1:0] st;
        logic [31:0] outv;
        pos = (pos_in == 0) ? 2 : pos_in;
        st = ST_OK;
        outv = '0;
        if (act == ACT_DUMP)
        begin
            if (shadow_count == 0)
                pending_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
            else
                for (int unsigned i = 0; i < shadow_count; i++)
                    pending_results.push_back(make_result(ST_OK, shadow_list[i],
                                                          i + 1 == shadow_count));
            return;
        end
        if (act inside {ACT_INS_HEAD, ACT_INS_END, ACT_INS_MID, ACT_INS_POS})
        begin
            if (shadow_count >= CAP)
                st = ST_FULL;
            else if (act == ACT_INS_HEAD)
                shadow_insert(0, v);
            else if (act == ACT_INS_END)
                shadow_insert(shadow_count, v);
            else if (act == ACT_INS_MID)
                shadow_insert(shadow_count / 2, v);
            else if (pos - 1 <= shadow_count)
                shadow_insert(pos - 1, v);
            else
                st = ST_NOT_FOUND;
        end
        else if (shadow_count == 0)
            st = ST_EMPTY;
        else if (act == ACT_DEL_HEAD)
            shadow_remove(0, outv);
        else if (act == ACT_DEL_VAL)
        begin
            st = ST_NOT_FOUND;
            for (int unsigned i = 0; i < shadow_count; i++)
                if (shadow_list[i] == v)
                begin
                    shadow_remove(i, outv);
                    st = ST_OK;
                    break;
                end
        end
        else if (pos <= shadow_count)
            shadow_remove(pos - 1, outv);
        else
            st = ST_NOT_FOUND;
        pending_results.push_back(make_result(st, outv, 1'b1));
    endtask

    task automatic send_beat(action_t act, logic [7:0] pos, logic [31:0] v);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata <= {5'd0, v, pos, act};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        predict_list_op(act, pos, v);
    endtask

    function automatic logic [31:0] pick_value();
        if (shadow_count > 0 && $urandom_range(0, 1))
            return shadow_list[$urandom_range(0, shadow_count - 1)];
        return $urandom_range(0, 3) == 0 ? $urandom_range(0, 7) : $urandom;
    endfunction

    task automatic add_row(action_t a, logic [7:0] p, logic [31:0] v, bit t = 0,
                           logic [1:0] st = ST_OK, logic [4:0] c = 0);
        list_row_t r;
        r.act = a; r.pos = p; r.val = v; r.typed = t; r.st = st; r.cnt = c;
        rows.push_back(r);
    endtask

    always @(posedge clk)
    begin
        list_result_t got, exp_r;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got.status = m_axis_tdata[1:0];
            got.value = m_axis_tdata[33:2];
            got.count = m_axis_tdata[38:34];
            got.last = m_axis_tlast;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (got.status !== exp_r.status)
                begin
                    $error("status expected %0d actual %0d", exp_r.status, got.status);
                    errors++;
                end
                if (got.value !== exp_r.value)
                begin
                    $error("out_value expected %h actual %h", exp_r.value, got.value);
                    errors++;
                end
                if (got.count !== exp_r.count)
                begin
                    $error("entry_count expected %0d actual %0d", exp_r.count, got.count);
                    errors++;
                end
                if (got.last !== exp_r.last)
                begin
                    $error("last expected %0d actual %0d", exp_r.last, got.last);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int wait_cycles;
        @(negedge rst_n or posedge rst_n);
        while (1)
        begin
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
                if (wait_cycles > 0)
                begin
                    m_axis_tready <= 1'b0;
                    repeat (wait_cycles) @(posedge clk);
                end
                m_axis_tready <= 1'b1;
                do @(posedge clk); while (!m_axis_tvalid);
            end
        end
    end

    initial
    begin
        int hold;
        wait (rst_n);
        repeat (200) @(posedge clk);
        hold_off = 1;
        for (hold = 0; hold < 600; hold++)
            @(posedge clk);
        hold_off = 0;
    end

    initial
    begin
        int n;
        action_t a;
        int unsigned drain;
        shadow_count = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(ACT_DUMP, 8'd0, 32'd0, 1, ST_EMPTY, 0);
        add_row(ACT_DEL_HEAD, 8'd0, 32'd0, 1, ST_EMPTY, 0);
        add_row(ACT_DEL_VAL, 8'd0, 32'd5, 1, ST_EMPTY, 0);
        add_row(ACT_DEL_POS, 8'd1, 32'd0, 1, ST_EMPTY, 0);
        add_row(ACT_INS_MID, 8'd0, 32'h7FFF_FFFF, 1, ST_OK, 1);
        add_row(ACT_INS_MID, 8'd0, 32'h8000_0000, 1, ST_OK, 2);
        add_row(ACT_INS_POS, 8'd0, 32'hFFFF_FFFF);
        add_row(ACT_INS_POS, 8'd4, 32'd1);
        add_row(ACT_INS_POS, 8'd6, 32'd2, 1, ST_NOT_FOUND, 4);
        add_row(ACT_INS_POS, 8'd255, 32'd2, 1, ST_NOT_FOUND, 4);
        add_row(ACT_INS_POS, 8'd1, 32'd3);
        add_row(ACT_INS_HEAD, 8'd255, 32'd0);
        add_row(ACT_INS_END, 8'd0, 32'h5555_AAAA);
        add_row(ACT_DUMP, 8'd0, 32'd0);
        add_row(ACT_DEL_POS, 8'd8, 32'd0, 1, ST_NOT_FOUND, 7);
        add_row(ACT_DEL_POS, 8'd0, 32'd0);
        add_row(ACT_DEL_POS, 8'd6, 32'd0);
        add_row(ACT_DEL_VAL, 8'd0, 32'h1234_5678, 1, ST_NOT_FOUND, 5);
        add_row(ACT_DEL_VAL, 8'd0, 32'h7FFF_FFFF);
        add_row(ACT_DEL_HEAD, 8'd0, 32'd0);
        for (int i = 0; i < 14; i++)
            add_row(ACT_INS_END, 8'd0, $urandom);
        add_row(ACT_INS_HEAD, 8'd0, 32'd9, 1, ST_FULL, 16);
        add_row(ACT_DUMP, 8'd0, 32'd0);

        foreach (rows[i])
        begin
            if (rows[i].typed)
            begin
                list_result_t r;
                r.status = rows[i].st;
                r.value = '0;
                r.count = rows[i].cnt;
                r.last = 1'b1;
                send_beat(rows[i].act, rows[i].pos, rows[i].val);
                void'(pending_results.pop_back());
                pending_results.push_back(r);
            end
            else
                send_beat(rows[i].act, rows[i].pos, rows[i].val);
        end

        for (n = 0; n < 265; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1: a = action_t'($urandom_range(0, 3));
                2: a = ACT_DUMP;
                3: a = ACT_DEL_VAL;
                4: a = ACT_DEL_POS;
                5: a = ACT_DEL_HEAD;
                default: a = action_t'($urandom_range(0, 7));
            endcase
            if (shadow_count > 12 && $urandom_range(0, 1))
                a = action_t'($urandom_range(4, 6));
            send_beat(a, ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                    : 8'($urandom_range(0, shadow_count + 2)),
                      pick_value());
        end
        s_axis_tvalid <= 1'b0;
        sending_done = 1;
        while (pending_results.size() != 0)
            @(posedge clk);
        for (drain = 0; drain < 100; drain++)
            @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ----- ordered_list_engine_unit.f -----
hdl/ole_pkg.sv
hdl/ordered_list_engine_unit.sv
tb/ordered_list_engine_unit_tb.sv
